>>> rtl/lkc_pkg.sv
package lkc_pkg;

	// item field widths
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;

	// defaults for the top level
	localparam int ENTRIES_DEF = 16;
	localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

	// configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	typedef enum logic [0:0] {
		REG_CAPACITY = 1'b0
	} reg_index_t;

	// item codes
	typedef enum logic {
		OP_GET = 1'b0,
		OP_SET = 1'b1
	} op_t;

	localparam logic [VAL_W-1:0] MISS_VALUE = '1;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_UPDATE,
		ST_RESP
	} state_t;

endpackage

>>> rtl/lkc_req_if.sv
interface lkc_req_if;
	import lkc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    op;
	logic signed [KEY_W-1:0] key;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, op, key, value, input ready);
	modport sink (input valid, op, key, value, output ready);

endinterface

>>> rtl/lkc_rsp_if.sv
interface lkc_rsp_if;
	import lkc_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    found;
	logic signed [VAL_W-1:0] read_value;
	logic                    evicted;
	logic signed [KEY_W-1:0] evicted_key;

	modport source (output valid, found, read_value, evicted, evicted_key, input ready);
	modport sink (input valid, found, read_value, evicted, evicted_key, output ready);

endinterface

>>> rtl/lru_key_value_cache.sv
// One item at a time: a get hit or a set makes a lookup pass over all ENTRIES entries and then a
// rank update pass over all entries, a get miss only the lookup pass (no update pass). No new
// request is taken until the previous result is loaded into the output register; the entry
// memory has one read and one write port.
// Reset: all entries invalid, entry count zero, capacity 16; memory contents are not cleared.
module lru_key_value_cache #(
	parameter int ENTRIES = lkc_pkg::ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lkc_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [lkc_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [lkc_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	lkc_req_if.sink                          req,
	lkc_rsp_if.source                        rsp
);
	import lkc_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RW = IW;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int XW = ((CW > CAP_W) ? CW : CAP_W) + 1;
	localparam int WORD_W = KEY_W + VAL_W + RW;
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	state_t state_q, state_d;

	// configuration
	logic [CAP_W-1:0] cap_q;
	logic             cfg_wr;

	// item being worked on
	logic             op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;

	// entry state
	logic [WORD_W-1:0]  mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [ENTRIES-1:0] valid_next;
	logic [CW-1:0]      count_q;

	// read pipeline
	logic [IW-1:0]     rd_idx_q;
	logic              issued_all_q;
	logic              issue;
	logic              rd_vld_s1;
	logic [IW-1:0]     idx_s1;
	logic [WORD_W-1:0] rdata_s1;
	logic [KEY_W-1:0]  rd_key;
	logic [VAL_W-1:0]  rd_value;
	logic [RW-1:0]     rd_rank;
	logic              rd_valid;
	logic              last_s1;

	// scan results
	logic             hit_q;
	logic [RW-1:0]    hit_rank_q;
	logic [VAL_W-1:0] hit_value_q;
	logic             vic_found_q;
	logic [IW-1:0]    vic_idx_q;
	logic [RW-1:0]    vic_rank_q;
	logic [KEY_W-1:0] vic_key_q;
	logic             free_found_q;
	logic [IW-1:0]    free_idx_q;
	logic [IW-1:0]    slot_q;
	logic             ins_q;

	// decision
	logic [XW-1:0]    cap_eff;
	logic [XW-1:0]    count_next;
	logic             do_insert;
	logic             do_evict;
	logic [IW-1:0]    ins_slot;

	// update write
	logic              wr_en;
	logic [WORD_W-1:0] wr_word;
	logic [RW-1:0]     new_rank;

	// result
	logic             res_found_q;
	logic [VAL_W-1:0] res_value_q;
	logic             res_evicted_q;
	logic [KEY_W-1:0] res_evk_q;
	logic             out_valid_q;
	logic             out_found_q;
	logic [VAL_W-1:0] out_value_q;
	logic             out_evicted_q;
	logic [KEY_W-1:0] out_evk_q;
	logic             out_load;

	// configuration port
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr[APB_ADDR_W-1] == REG_CAPACITY) begin
			prdata = APB_DATA_W'(cap_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAPACITY_RESET;
		end else if (cfg_wr && paddr[APB_ADDR_W-1] == REG_CAPACITY) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// fields of the word read back
	assign rd_key   = rdata_s1[WORD_W-1 -: KEY_W];
	assign rd_value = rdata_s1[RW +: VAL_W];
	assign rd_rank  = rdata_s1[RW-1:0];
	assign rd_valid = valid_q[idx_s1];
	assign last_s1  = rd_vld_s1 && (idx_s1 == LAST_IDX);

	// effective capacity and eviction decision
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = XW'(1);
		end else if (XW'(cap_q) > XW'(ENTRIES)) begin
			cap_eff = XW'(ENTRIES);
		end else begin
			cap_eff = XW'(cap_q);
		end
		count_next = XW'(count_q) + XW'(1);
		do_insert  = (op_q == OP_SET) && !hit_q;
		do_evict   = do_insert && (count_next > cap_eff) && (count_q != '0) && vic_found_q;
		if (do_evict && (!free_found_q || vic_idx_q < free_idx_q)) begin
			ins_slot = vic_idx_q;
		end else begin
			ins_slot = free_idx_q;
		end
	end

	// valid bits after an insert, victim cleared before the new slot is set
	always_comb begin
		valid_next = valid_q;
		if (do_evict) begin
			valid_next[vic_idx_q] = 1'b0;
		end
		valid_next[ins_slot] = 1'b1;
	end

	// rank and word written back during the update pass
	always_comb begin
		new_rank = rd_rank;
		if (ins_q || rd_rank < hit_rank_q) begin
			new_rank = rd_rank + RW'(1);
		end
		if (idx_s1 == slot_q) begin
			wr_word = {key_q, (op_q == OP_SET) ? value_q : rd_value, RW'(0)};
		end else begin
			wr_word = {rd_key, rd_value, new_rank};
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (last_s1) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (hit_q || op_q == OP_SET) begin
					state_d = ST_UPDATE;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_UPDATE: begin
				if (last_s1) state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!out_valid_q || rsp.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		req.ready = 1'b0;
		issue     = 1'b0;
		wr_en     = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_SCAN: issue = !issued_all_q;
			ST_DECIDE: ;
			ST_UPDATE: begin
				issue = !issued_all_q;
				wr_en = rd_vld_s1 && (idx_s1 == slot_q || rd_valid);
			end
			ST_RESP: out_load = !out_valid_q || rsp.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// entry memory: one read port, one write port
	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx_s1] <= wr_word;
		end
	end

	// address counter and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q     <= '0;
			issued_all_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			idx_s1       <= '0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				idx_s1   <= rd_idx_q;
				rd_idx_q <= rd_idx_q + IW'(1);
				if (rd_idx_q == LAST_IDX) issued_all_q <= 1'b1;
			end
			if (state_q == ST_IDLE || state_q == ST_DECIDE) begin
				rd_idx_q     <= '0;
				issued_all_q <= 1'b0;
			end
		end
	end

	// request capture and lookup scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q        <= 1'b0;
			vic_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			hit_q        <= 1'b0;
			vic_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (state_q == ST_SCAN && rd_vld_s1) begin
			if (rd_valid && rd_key == key_q && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (rd_valid && (!vic_found_q || rd_rank >= vic_rank_q)) begin
				vic_found_q <= 1'b1;
			end
			if (!rd_valid && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q    <= req.op;
			key_q   <= req.key;
			value_q <= req.value;
		end
		if (state_q == ST_SCAN && rd_vld_s1) begin
			if (rd_valid && rd_key == key_q && !hit_q) begin
				slot_q      <= idx_s1;
				hit_rank_q  <= rd_rank;
				hit_value_q <= rd_value;
			end
			if (rd_valid && (!vic_found_q || rd_rank >= vic_rank_q)) begin
				vic_idx_q  <= idx_s1;
				vic_rank_q <= rd_rank;
				vic_key_q  <= rd_key;
			end
			if (!rd_valid && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (state_q == ST_DECIDE) begin
			ins_q         <= do_insert;
			res_found_q   <= hit_q;
			res_value_q   <= (hit_q && op_q == OP_GET) ? hit_value_q : MISS_VALUE;
			res_evicted_q <= do_evict;
			res_evk_q     <= do_evict ? vic_key_q : '0;
			if (do_insert) slot_q <= ins_slot;
		end
	end

	// valid bits and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (state_q == ST_DECIDE && do_insert) begin
			valid_q <= valid_next;
			if (!do_evict) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_found_q   <= res_found_q;
			out_value_q   <= res_value_q;
			out_evicted_q <= res_evicted_q;
			out_evk_q     <= res_evk_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.found       = out_found_q;
	assign rsp.read_value  = out_value_q;
	assign rsp.evicted     = out_evicted_q;
	assign rsp.evicted_key = out_evk_q;

endmodule

>>> verif/lru_reply_checker.sv
`timescale 1ns / 1ps

module lru_reply_checker #(
	parameter int ENTRIES = lkc_pkg::ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [lkc_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lkc_pkg::APB_DATA_W-1:0] pwdata,
	lkc_req_if                             req,
	lkc_rsp_if                             rsp,
	output int                             fault_count,
	output int                             pending,
	output int                             hit_count,
	output int                             evict_count
);
	import lkc_pkg::*;

	typedef struct packed {
		logic             found;
		logic [VAL_W-1:0] read_value;
		logic             evicted;
		logic [KEY_W-1:0] evicted_key;
	} cache_reply_t;

	// shadow copy of the cache contents
	logic [KEY_W-1:0] slot_key [ENTRIES];
	logic [VAL_W-1:0] slot_val [ENTRIES];
	bit               slot_live [ENTRIES];
	int unsigned      slot_age [ENTRIES];
	int unsigned      live_count;
	logic [CAP_W-1:0] cap_limit;

	cache_reply_t owed_replies [$];

	// one get or set against the shadow cache, returns its reply
	function automatic cache_reply_t lru_access(op_t op, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
		cache_reply_t r;
		int hit;
		int victim;
		int free_slot;
		int unsigned oldest;
		int unsigned age;
		int unsigned eff;
		r.found = 1'b0;
		r.read_value = MISS_VALUE;
		r.evicted = 1'b0;
		r.evicted_key = '0;
		hit = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (slot_live[i] && slot_key[i] == k && hit < 0)
				hit = i;
		// zero acts as one, anything above the slot count saturates
		eff = (cap_limit == 0) ? 1 : ((cap_limit > ENTRIES) ? ENTRIES : cap_limit);
		if (hit >= 0) begin
			r.found = 1'b1;
			if (op == OP_GET)
				r.read_value = slot_val[hit];
			else
				slot_val[hit] = v;
			age = slot_age[hit];
			for (int i = 0; i < ENTRIES; i++)
				if (slot_live[i] && slot_age[i] < age)
					slot_age[i]++;
			slot_age[hit] = 0;
		end else if (op == OP_SET) begin
			// victim picked before the new key goes in
			if (live_count + 1 > eff && live_count > 0) begin
				victim = -1;
				oldest = 0;
				for (int i = 0; i < ENTRIES; i++) begin
					if (slot_live[i] && (victim < 0 || slot_age[i] >= oldest)) begin
						victim = i;
						oldest = slot_age[i];
					end
				end
				if (victim >= 0) begin
					r.evicted = 1'b1;
					r.evicted_key = slot_key[victim];
					slot_live[victim] = 1'b0;
					slot_age[victim] = 0;
					live_count--;
				end
			end
			free_slot = -1;
			for (int i = 0; i < ENTRIES; i++)
				if (!slot_live[i] && free_slot < 0)
					free_slot = i;
			if (free_slot >= 0) begin
				for (int i = 0; i < ENTRIES; i++)
					if (slot_live[i])
						slot_age[i]++;
				slot_key[free_slot] = k;
				slot_val[free_slot] = v;
				slot_live[free_slot] = 1'b1;
				slot_age[free_slot] = 0;
				live_count++;
			end
		end
		return r;
	endfunction

	// watch register writes, request and reply transfers
	always @(posedge clk or negedge arst_n) begin
		cache_reply_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				slot_live[i] = 1'b0;
				slot_age[i] = 0;
			end
			live_count = 0;
			cap_limit = CAPACITY_RESET;
			owed_replies.delete();
			fault_count <= 0;
			pending <= 0;
			hit_count <= 0;
			evict_count <= 0;
		end else begin
			// reply transfer first: it belongs to an older request
			if (rsp.valid && rsp.ready) begin
				if (owed_replies.size() == 0) begin
					$error("reply transfer with no request outstanding");
					errs++;
				end else begin
					want = owed_replies.pop_front();
					if (rsp.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, rsp.found);
						errs++;
					end
					if (rsp.read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d",
							$signed(want.read_value), $signed(rsp.read_value));
						errs++;
					end
					if (rsp.evicted !== want.evicted) begin
						$error("evicted: expected %0d, got %0d", want.evicted, rsp.evicted);
						errs++;
					end
					if (rsp.evicted_key !== want.evicted_key) begin
						$error("evicted_key: expected %0d, got %0d",
							$signed(want.evicted_key), $signed(rsp.evicted_key));
						errs++;
					end
				end
			end
			fault_count <= fault_count + errs;
			if (req.valid && req.ready) begin
				want = lru_access(op_t'(req.op), req.key, req.value);
				owed_replies.push_back(want);
				if (want.found)
					hit_count <= hit_count + 1;
				if (want.evicted)
					evict_count <= evict_count + 1;
			end
			// capacity register write
			if (psel && penable && pwrite && pready &&
					paddr == APB_ADDR_W'(4 * int'(REG_CAPACITY)))
				cap_limit = pwdata[CAP_W-1:0];
			pending <= owed_replies.size();
		end
	end

endmodule

>>> verif/tb_lru_key_value_cache.sv
`timescale 1ns / 1ps

module tb_lru_key_value_cache;
	import lkc_pkg::*;

	localparam int SLOTS = ENTRIES_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 60;
	localparam int POOL = 24;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	lkc_req_if req_if ();
	lkc_rsp_if rsp_if ();

	int fault_count;
	int pending;
	int hit_count;
	int evict_count;
	int cycle_count;
	int items_sent;
	int cap_writes;
	bit calm;

	logic [KEY_W-1:0] key_pool [POOL];
	logic [KEY_W-1:0] corner [4];

	lru_key_value_cache #(.ENTRIES(SLOTS)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_if),
		.rsp     (rsp_if)
	);

	lru_reply_checker #(.ENTRIES(SLOTS)) reply_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.req         (req_if),
		.rsp         (rsp_if),
		.fault_count (fault_count),
		.pending     (pending),
		.hit_count   (hit_count),
		.evict_count (evict_count)
	);

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// run watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// reply side: random stall before each transfer, none while calm
	initial begin
		int w;
		rsp_if.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			w = calm ? 0 : $urandom_range(0, 16);
			if (w > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			@(posedge clk);
			while (!(rsp_if.valid && rsp_if.ready)) @(posedge clk);
		end
	end

	// one request transfer after a random gap, none while calm
	task automatic send_req(op_t op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
		int w;
		w = calm ? 0 : $urandom_range(0, 16);
		if (w > 0) begin
			req_if.valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.op <= op;
		req_if.key <= k;
		req_if.value <= v;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		items_sent++;
	endtask

	// stop sending and let every reply come back
	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// setup then access cycle, only while idle
	task automatic set_capacity(logic [CAP_W-1:0] cap);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(4 * int'(REG_CAPACITY));
		pwdata <= APB_DATA_W'(cap);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cap_writes++;
	endtask

	initial begin
		logic [CAP_W-1:0] cap_plan [PHASES];
		logic [KEY_W-1:0] k;
		logic [VAL_W-1:0] v;
		int sel;

		// every input known from time zero
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_if.valid <= 1'b0;
		req_if.op <= OP_GET;
		req_if.key <= '0;
		req_if.value <= '0;
		items_sent = 0;
		cap_writes = 0;
		calm = 1'b0;
		corner[0] = 32'h8000_0000;
		corner[1] = 32'h7fff_ffff;
		corner[2] = 32'h0000_0000;
		corner[3] = 32'hffff_ffff;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes at the reset capacity
		send_req(OP_GET, 32'h0, 32'h1);
		send_req(OP_SET, 32'h8000_0000, 32'h7fff_ffff);
		send_req(OP_SET, 32'h7fff_ffff, 32'h8000_0000);
		send_req(OP_SET, 32'h0, 32'hffff_ffff);
		send_req(OP_GET, 32'h8000_0000, 32'h0);
		send_req(OP_GET, 32'h7fff_ffff, 32'h0);
		send_req(OP_GET, 32'h0, 32'h5555_5555);
		send_req(OP_SET, 32'h8000_0000, 32'h0);
		send_req(OP_GET, 32'hffff_ffff, 32'h0);
		send_req(OP_SET, 32'hffff_ffff, 32'h1234_5678);
		send_req(OP_GET, 32'h8000_0000, 32'haaaa_aaaa);

		// capacity lowered below the entry count
		set_capacity(CAP_W'(2));
		send_req(OP_SET, 32'd100, 32'd1);
		send_req(OP_SET, 32'd101, 32'd2);
		send_req(OP_GET, 32'd100, 32'd0);
		send_req(OP_SET, 32'd102, 32'd3);
		send_req(OP_GET, 32'd101, 32'd0);

		// zero capacity acts as one, new key never the victim
		set_capacity(CAP_W'(0));
		send_req(OP_SET, 32'd200, 32'd5);
		send_req(OP_SET, 32'd201, 32'd6);
		send_req(OP_GET, 32'd201, 32'd0);
		send_req(OP_SET, 32'd201, 32'd7);
		send_req(OP_GET, 32'd200, 32'd0);

		// random phases, saturated and lowered capacities among them
		cap_plan[0] = CAP_W'(31);
		cap_plan[1] = CAP_W'(8);
		cap_plan[2] = CAP_W'(1);
		cap_plan[3] = CAP_W'(17);
		cap_plan[4] = CAP_W'(3);
		cap_plan[5] = CAP_W'(0);
		cap_plan[6] = CAP_W'($urandom_range(0, 31));
		cap_plan[7] = CAP_W'(16);
		cap_plan[8] = CAP_W'(12);
		cap_plan[9] = CAP_W'($urandom_range(1, 16));
		for (int p = 0; p < PHASES; p++) begin
			set_capacity(cap_plan[p]);
			calm = (p % 4 == 3);
			// small key set so hits and evictions both show up
			for (int i = 0; i < POOL; i++)
				key_pool[i] = (i < 4) ? corner[i] : $urandom;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < 85)
					k = key_pool[$urandom_range(0, POOL - 1)];
				else if (sel < 95)
					k = $urandom;
				else
					k = corner[$urandom_range(0, 3)];
				sel = $urandom_range(0, 99);
				if (sel < 90)
					v = $urandom;
				else
					v = corner[$urandom_range(0, 3)];
				send_req($urandom_range(0, 1) ? OP_SET : OP_GET, k, v);
			end
		end
		calm = 1'b0;

		// wrap up
		drain();
		repeat (2 * SLOTS + 8) @(posedge clk);
		$display("sent %0d requests over %0d capacity writes", items_sent, cap_writes);
		$display("lookups found %0d keys, %0d entries evicted", hit_count, evict_count);
		if (fault_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> files.f
rtl/lkc_pkg.sv
rtl/lkc_req_if.sv
rtl/lkc_rsp_if.sv
rtl/lru_key_value_cache.sv
verif/lru_reply_checker.sv
verif/tb_lru_key_value_cache.sv
